[src/convolution_3x3_zero_pad_unit_defines.svh]
// Assertion helpers shared by the convolution unit RTL.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef CONVOLUTION_3X3_ZERO_PAD_UNIT_DEFINES_SVH
`define CONVOLUTION_3X3_ZERO_PAD_UNIT_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define CV3_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define CV3_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

[src/cv3_pkg.sv]
package cv3_pkg;

    // Field and datapath widths.
    localparam int SAMPLE_W     = 16;
    localparam int COEF_W       = 16;
    localparam int KERNEL_ROW_W = 48;
    localparam int PROD_W       = 32;
    localparam int RESULT_W     = 35;
    localparam int DIM_W        = 11;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 48;
    localparam int TAPS         = 3;

    // Output queue geometry.
    localparam int FIFO_DEPTH   = 8;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_COUNT_W = $clog2(FIFO_DEPTH + 1);

    // Input command code for an image pixel; anything else is a drain slot.
    localparam logic CMD_PIXEL = 1'b0;

    typedef logic signed [SAMPLE_W-1:0]  sample_t;
    typedef logic [KERNEL_ROW_W-1:0]     kernel_row_t;
    typedef logic signed [PROD_W-1:0]    product_t;
    typedef logic signed [RESULT_W-1:0]  result_value_t;

    // One line store entry: sample two rows back and sample one row back.
    typedef struct packed {
        sample_t upper;
        sample_t lower;
    } line_pair_t;

    // Per-item control that travels with the window into the MAC.
    typedef struct packed {
        logic has_result;
        logic last;
        logic top_en;
        logic bottom_en;
        logic left_en;
        logic right_en;
    } tap_ctrl_t;

    // Occupancy of the MAC stages, used for output flow control.
    typedef struct packed {
        logic product_busy;
        logic sum_busy;
    } mac_status_t;

    typedef struct packed {
        result_value_t value;
        logic          last;
    } result_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_KERNEL_TOP    = 3'd0,
        CFG_KERNEL_MIDDLE = 3'd1,
        CFG_KERNEL_BOTTOM = 3'd2,
        CFG_IMAGE_WIDTH   = 3'd3,
        CFG_IMAGE_HEIGHT  = 3'd4
    } cfg_index_t;

endpackage

[src/convolution_3x3_zero_pad_unit.sv]
// 3x3 true convolution with zero padding over a raster pixel stream. One item (pixel or
// drain slot) is taken every clock cycle while pixel_ready is high; the output for pixel p
// is produced by item p+width+1 and reaches the result port through the line store, product
// and sum stages and the result queue. The rate is set by the single line store memory,
// which serves one read (at item entry) and one write (in the line store stage) per item,
// with a forwarding path for back-to-back hits on the same column. Results wait in an
// eight-entry queue, so the input keeps flowing while results are held up, until eight
// results are waiting in the line store, product and sum stages and the queue together.
// The line store needs no clearing after reset or a geometry change: stale rows only ever
// fall under the zero-padding mask. Writing image_width or image_height restarts the frame.
`include "convolution_3x3_zero_pad_unit_defines.svh"

module convolution_3x3_zero_pad_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write_enable,
    input  logic [cv3_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [cv3_pkg::CFG_DATA_W-1:0]         cfg_write_data,
    input  logic                                   pixel_valid,
    output logic                                   pixel_ready,
    input  logic                                   command,
    input  logic signed [cv3_pkg::SAMPLE_W-1:0]    pixel,
    output logic                                   result_valid,
    input  logic                                   result_ready,
    output logic signed [cv3_pkg::RESULT_W-1:0]    result_value,
    output logic                                   frame_end
);

    localparam int COL_W        = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W        = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W        = $clog2(MAX_HEIGHT + 3);
    localparam int ADDR_W       = $clog2(MAX_WIDTH);
    localparam int OCC_W        = cv3_pkg::FIFO_COUNT_W + 1;
    localparam int RESET_WIDTH  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int RESET_HEIGHT = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

    // Configuration registers.
    cv3_pkg::kernel_row_t kernel_top_reg;
    cv3_pkg::kernel_row_t kernel_middle_reg;
    cv3_pkg::kernel_row_t kernel_bottom_reg;
    logic [COL_W-1:0]     width_reg;
    logic [HGT_W-1:0]     height_reg;
    logic [cv3_pkg::DIM_W-1:0] cfg_dim;
    logic [COL_W-1:0]     width_clamped;
    logic [HGT_W-1:0]     height_clamped;
    logic                 geometry_write;

    // Frame position.
    logic [COL_W-1:0]     col_reg;
    logic [COL_W-1:0]     col_next;
    logic [ROW_W-1:0]     row_reg;
    logic [ROW_W-1:0]     row_next;

    // Item decode.
    logic                 accept;
    logic [COL_W-1:0]     col_cur;
    logic [ROW_W-1:0]     row_cur;
    logic [COL_W-1:0]     width_minus1;
    logic [ROW_W-1:0]     height_row;
    logic [ROW_W-1:0]     height_plus1;
    logic [ROW_W-1:0]     height_minus1;
    logic [COL_W-1:0]     out_col;
    logic [ROW_W-1:0]     out_row;
    logic [COL_W-1:0]     col_step;
    logic [COL_W-1:0]     item_col_next;
    logic [ROW_W-1:0]     item_row_next;
    cv3_pkg::sample_t     sample_in;
    cv3_pkg::tap_ctrl_t   ctrl_in;

    // Line store stage.
    logic                 s1_valid_reg;
    cv3_pkg::sample_t     s1_sample_reg;
    logic [ADDR_W-1:0]    s1_addr_reg;
    cv3_pkg::tap_ctrl_t   s1_ctrl_reg;
    cv3_pkg::line_pair_t  line_rd;
    cv3_pkg::line_pair_t  line_wr;
    cv3_pkg::tap_ctrl_t   mac_ctrl;

    // MAC and output queue.
    logic                 sum_valid;
    cv3_pkg::result_t     sum_out;
    cv3_pkg::mac_status_t mac_status;
    cv3_pkg::result_t     fifo_head;
    logic                 fifo_pop;
    logic [cv3_pkg::FIFO_COUNT_W-1:0] fifo_count;
    logic [OCC_W-1:0]     occupancy;

    // Geometry values are clamped to the supported range when written.
    assign cfg_dim = cfg_write_data[cv3_pkg::DIM_W-1:0];

    always_comb
    begin
        if (cfg_dim == '0)
        begin
            width_clamped  = COL_W'(1);
            height_clamped = HGT_W'(1);
        end
        else
        begin
            if (32'(cfg_dim) > 32'(MAX_WIDTH))
            begin
                width_clamped = COL_W'(MAX_WIDTH);
            end
            else
            begin
                width_clamped = COL_W'(cfg_dim);
            end
            if (32'(cfg_dim) > 32'(MAX_HEIGHT))
            begin
                height_clamped = HGT_W'(MAX_HEIGHT);
            end
            else
            begin
                height_clamped = HGT_W'(cfg_dim);
            end
        end
    end

    always_comb
    begin
        case (cv3_pkg::cfg_index_t'(cfg_index))
            cv3_pkg::CFG_IMAGE_WIDTH:  geometry_write = cfg_write_enable;
            cv3_pkg::CFG_IMAGE_HEIGHT: geometry_write = cfg_write_enable;
            default:                   geometry_write = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_top_reg    <= '0;
            kernel_middle_reg <= '0;
            kernel_bottom_reg <= '0;
            width_reg         <= COL_W'(RESET_WIDTH);
            height_reg        <= HGT_W'(RESET_HEIGHT);
        end
        else if (cfg_write_enable)
        begin
            case (cv3_pkg::cfg_index_t'(cfg_index))
                cv3_pkg::CFG_KERNEL_TOP:    kernel_top_reg    <= cfg_write_data;
                cv3_pkg::CFG_KERNEL_MIDDLE: kernel_middle_reg <= cfg_write_data;
                cv3_pkg::CFG_KERNEL_BOTTOM: kernel_bottom_reg <= cfg_write_data;
                cv3_pkg::CFG_IMAGE_WIDTH:   width_reg         <= width_clamped;
                cv3_pkg::CFG_IMAGE_HEIGHT:  height_reg        <= height_clamped;
                default:                    ;
            endcase
        end
    end

    // Position of the incoming item, its sample and the output pixel it completes.
    assign height_row    = ROW_W'(height_reg);
    assign height_plus1  = height_row + ROW_W'(1);
    assign height_minus1 = height_row - ROW_W'(1);
    assign width_minus1  = width_reg - COL_W'(1);

    always_comb
    begin
        col_cur = col_reg;
        row_cur = row_reg;
        if (col_reg >= width_reg || row_reg > height_plus1)
        begin
            col_cur = '0;
            row_cur = '0;
        end

        if (command == cv3_pkg::CMD_PIXEL && row_cur < height_row)
        begin
            sample_in = pixel;
        end
        else
        begin
            sample_in = '0;
        end

        if (col_cur != '0)
        begin
            out_col = col_cur - COL_W'(1);
            out_row = row_cur - ROW_W'(1);
        end
        else
        begin
            out_col = width_minus1;
            out_row = row_cur - ROW_W'(2);
        end

        ctrl_in.has_result = (row_cur >= ROW_W'(2)) || (row_cur == ROW_W'(1) && col_cur != '0);
        ctrl_in.last       = ctrl_in.has_result && out_row == height_minus1
                          && out_col == width_minus1;
        ctrl_in.top_en     = (out_row != '0);
        ctrl_in.bottom_en  = (out_row < height_minus1);
        ctrl_in.left_en    = (out_col != '0);
        ctrl_in.right_en   = (out_col < width_minus1);

        col_step = col_cur + COL_W'(1);
        if (col_step >= width_reg)
        begin
            item_col_next = '0;
            item_row_next = row_cur + ROW_W'(1);
        end
        else
        begin
            item_col_next = col_step;
            item_row_next = row_cur;
        end
        if (ctrl_in.last)
        begin
            item_col_next = '0;
            item_row_next = '0;
        end
    end

    // Frame counters; a geometry write restarts the frame.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (geometry_write)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            col_next = item_col_next;
            row_next = item_row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Flow control: room for every result in flight plus one more.
    assign occupancy = OCC_W'(fifo_count)
                     + OCC_W'(s1_valid_reg && s1_ctrl_reg.has_result)
                     + OCC_W'(mac_status.product_busy)
                     + OCC_W'(mac_status.sum_busy);
    assign pixel_ready = (occupancy < OCC_W'(cv3_pkg::FIFO_DEPTH));
    assign accept      = pixel_valid && pixel_ready;

    // Line store stage: the read issued at entry returns here, and the column is written back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_ctrl_reg  <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s1_ctrl_reg  <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= sample_in;
            s1_addr_reg   <= col_cur[ADDR_W-1:0];
        end
    end

    assign line_wr.upper = line_rd.lower;
    assign line_wr.lower = s1_sample_reg;

    cv3_line_buffer #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buffer (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (col_cur[ADDR_W-1:0]),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (line_wr),
        .rd_data (line_rd)
    );

    always_comb
    begin
        mac_ctrl            = s1_ctrl_reg;
        mac_ctrl.has_result = s1_valid_reg && s1_ctrl_reg.has_result;
    end

    cv3_mac u_mac (
        .clk           (clk),
        .rst_n         (rst_n),
        .shift_en      (s1_valid_reg),
        .ctrl          (mac_ctrl),
        .col_top       (line_rd.upper),
        .col_middle    (line_rd.lower),
        .col_bottom    (s1_sample_reg),
        .kernel_top    (kernel_top_reg),
        .kernel_middle (kernel_middle_reg),
        .kernel_bottom (kernel_bottom_reg),
        .sum_valid     (sum_valid),
        .sum_out       (sum_out),
        .status        (mac_status)
    );

    // Output beats come from the head of the result queue.
    assign fifo_pop = result_valid && result_ready;

    cv3_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (sum_valid),
        .push_data (sum_out),
        .pop       (fifo_pop),
        .head      (fifo_head),
        .not_empty (result_valid),
        .count     (fifo_count)
    );

    assign result_value = fifo_head.value;
    assign frame_end    = fifo_head.last;

    `CV3_ASSERT_ALWAYS(a_col_in_range, col_reg < width_reg, "column counter beyond image width")
    `CV3_ASSERT_ALWAYS(a_row_in_range, row_reg <= height_plus1, "row counter beyond drain rows")

endmodule

[src/cv3_line_buffer.sv]
module cv3_line_buffer #(
    parameter int DEPTH = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  cv3_pkg::line_pair_t        wr_data,
    output cv3_pkg::line_pair_t        rd_data
);

    cv3_pkg::line_pair_t mem [DEPTH];
    cv3_pkg::line_pair_t mem_rd_reg;
    cv3_pkg::line_pair_t bypass_data_reg;
    logic                bypass_reg;

    // Single write port and single registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_rd_reg <= mem[rd_addr];
        end
    end

    // A read that collides with the write of the same cycle returns the new data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            bypass_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            bypass_data_reg <= wr_data;
        end
    end

    assign rd_data = bypass_reg ? bypass_data_reg : mem_rd_reg;

endmodule

[src/cv3_mac.sv]
module cv3_mac (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   shift_en,
    input  cv3_pkg::tap_ctrl_t     ctrl,
    input  cv3_pkg::sample_t       col_top,
    input  cv3_pkg::sample_t       col_middle,
    input  cv3_pkg::sample_t       col_bottom,
    input  cv3_pkg::kernel_row_t   kernel_top,
    input  cv3_pkg::kernel_row_t   kernel_middle,
    input  cv3_pkg::kernel_row_t   kernel_bottom,
    output logic                   sum_valid,
    output cv3_pkg::result_t       sum_out,
    output cv3_pkg::mac_status_t   status
);

    localparam int TAPS  = cv3_pkg::TAPS;
    localparam int NPROD = TAPS * TAPS;

    cv3_pkg::sample_t    win_reg  [TAPS][TAPS];
    cv3_pkg::product_t   prod_next[NPROD];
    cv3_pkg::product_t   prod_reg [NPROD];
    cv3_pkg::kernel_row_t krow    [TAPS];
    cv3_pkg::tap_ctrl_t  s2_ctrl_reg;
    logic                s2_valid_reg;
    logic                s3_valid_reg;
    logic                s3_last_reg;
    cv3_pkg::result_value_t acc;

    // The window shifts left by one column for every item; the new column enters on the right.
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            for (int a = 0; a < TAPS; a++)
            begin
                for (int b = 0; b < TAPS - 1; b++)
                begin
                    win_reg[a][b] <= win_reg[a][b+1];
                end
            end
            win_reg[0][TAPS-1] <= col_top;
            win_reg[1][TAPS-1] <= col_middle;
            win_reg[2][TAPS-1] <= col_bottom;
        end
    end

    // Stage control for the product and sum stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_ctrl_reg  <= '0;
            s3_valid_reg <= 1'b0;
            s3_last_reg  <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= shift_en && ctrl.has_result;
            s2_ctrl_reg  <= ctrl;
            s3_valid_reg <= s2_valid_reg;
            s3_last_reg  <= s2_ctrl_reg.last;
        end
    end

    assign krow[0] = kernel_top;
    assign krow[1] = kernel_middle;
    assign krow[2] = kernel_bottom;

    // Nine masked products; the kernel is applied flipped in both directions.
    always_comb
    begin
        logic                             tap_en;
        logic signed [cv3_pkg::COEF_W-1:0] coef;
        for (int a = 0; a < TAPS; a++)
        begin
            for (int b = 0; b < TAPS; b++)
            begin
                tap_en = (a != 0 || s2_ctrl_reg.top_en)
                      && (a != TAPS - 1 || s2_ctrl_reg.bottom_en)
                      && (b != 0 || s2_ctrl_reg.left_en)
                      && (b != TAPS - 1 || s2_ctrl_reg.right_en);
                coef = $signed(krow[TAPS-1-a][cv3_pkg::COEF_W*(TAPS-1-b) +: cv3_pkg::COEF_W]);
                if (tap_en)
                begin
                    prod_next[a*TAPS+b] = coef * win_reg[a][b];
                end
                else
                begin
                    prod_next[a*TAPS+b] = '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NPROD; i++)
        begin
            prod_reg[i] <= prod_next[i];
        end
    end

    // Exact sum of the registered products.
    always_comb
    begin
        acc = cv3_pkg::RESULT_W'(prod_reg[0]);
        for (int i = 1; i < NPROD; i++)
        begin
            acc = acc + cv3_pkg::RESULT_W'(prod_reg[i]);
        end
    end

    assign sum_valid           = s3_valid_reg;
    assign sum_out.value       = acc;
    assign sum_out.last        = s3_last_reg;
    assign status.product_busy = s2_valid_reg;
    assign status.sum_busy     = s3_valid_reg;

endmodule

[src/cv3_out_fifo.sv]
`include "convolution_3x3_zero_pad_unit_defines.svh"

module cv3_out_fifo (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    input  cv3_pkg::result_t                   push_data,
    input  logic                               pop,
    output cv3_pkg::result_t                   head,
    output logic                               not_empty,
    output logic [cv3_pkg::FIFO_COUNT_W-1:0]   count
);

    localparam int PTR_W = cv3_pkg::FIFO_PTR_W;
    localparam int CNT_W = cv3_pkg::FIFO_COUNT_W;

    cv3_pkg::result_t   entries_reg [cv3_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    assign head      = entries_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

    `CV3_ASSERT_ALWAYS(a_no_overflow, !push || (count_reg != CNT_W'(cv3_pkg::FIFO_DEPTH)), "result queue written while full")
    `CV3_ASSERT_NEXT(a_count_grows, push && !pop, count_reg == $past(count_reg) + CNT_W'(1), "result queue count did not follow a write")

endmodule

[dv/tb_convolution_3x3_zero_pad_unit.sv]
`timescale 1ns / 1ps

module tb_convolution_3x3_zero_pad_unit;

    localparam int LINE_MAX      = 1024;
    localparam int ROWS_MAX      = 1024;
    localparam int IDLE_PAUSE    = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_BEATS  = 300;
    localparam int MIN_PHASES    = 8;
    localparam logic CMD_DRAIN   = ~cv3_pkg::CMD_PIXEL;

    typedef struct packed {
        logic             command;
        cv3_pkg::sample_t sample;
    } pixel_beat_t;

    typedef enum {
        FRAME_CLEAN,
        FRAME_CUT,
        FRAME_NOISE
    } frame_style_t;

    logic                             clk              = 1'b0;
    logic                             rst_n            = 1'b0;
    logic                             cfg_write_enable = 1'b0;
    logic [cv3_pkg::CFG_INDEX_W-1:0]  cfg_index        = '0;
    logic [cv3_pkg::CFG_DATA_W-1:0]   cfg_write_data   = '0;
    logic                             pixel_valid      = 1'b0;
    logic                             command          = cv3_pkg::CMD_PIXEL;
    cv3_pkg::sample_t                 pixel            = '0;
    logic                             result_ready     = 1'b0;
    logic                             pixel_ready;
    logic                             result_valid;
    cv3_pkg::result_value_t           result_value;
    logic                             frame_end;

    // Predictor state: line stores, window, kernel, geometry and raster position.
    logic [cv3_pkg::SAMPLE_W-1:0]     upper_line [LINE_MAX];
    logic [cv3_pkg::SAMPLE_W-1:0]     lower_line [LINE_MAX];
    cv3_pkg::sample_t                 window [9];
    cv3_pkg::kernel_row_t             kernel_rows [3];
    logic [cv3_pkg::DIM_W-1:0]        width_setting;
    logic [cv3_pkg::DIM_W-1:0]        height_setting;
    int unsigned                      col_pos;
    int unsigned                      row_pos;

    pixel_beat_t                      beats_pending [$];
    cv3_pkg::result_t                 expected_sums [$];
    int                               error_count        = 0;
    int                               stall_cycles       = 0;
    int                               sender_idle_pct    = 0;
    int                               receiver_stall_pct = 0;

    convolution_3x3_zero_pad_unit #(
        .MAX_WIDTH  (LINE_MAX),
        .MAX_HEIGHT (ROWS_MAX)
    ) u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_write_data   (cfg_write_data),
        .pixel_valid      (pixel_valid),
        .pixel_ready      (pixel_ready),
        .command          (command),
        .pixel            (pixel),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .result_value     (result_value),
        .frame_end        (frame_end)
    );

    always #5 clk = ~clk;

    // Zero maps to one and anything past the store size maps to the store size.
    function automatic int unsigned effective_dim(logic [cv3_pkg::DIM_W-1:0] v,
                                                  int unsigned limit);
        if (v == 0)
        begin
            return 1;
        end
        if (v > limit)
        begin
            return limit;
        end
        return v;
    endfunction

    // Uniform samples half of the time; otherwise the extremes, zero or minus one.
    function automatic logic [cv3_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Advance the raster delay line by one accepted beat and queue the sum it releases.
    function automatic void predict_beat(logic cmd, cv3_pkg::sample_t px);
        int unsigned      w;
        int unsigned      h;
        int unsigned      c;
        int unsigned      r;
        int unsigned      pr;
        int unsigned      pc;
        cv3_pkg::sample_t column [3];
        cv3_pkg::sample_t coef;
        logic             has_result;
        logic             is_last;
        longint           sum;
        cv3_pkg::result_t entry;

        w   = effective_dim(width_setting, LINE_MAX);
        h   = effective_dim(height_setting, ROWS_MAX);
        c   = col_pos;
        r   = row_pos;
        sum = 0;
        if (c >= w || r > h + 1)
        begin
            c = 0;
            r = 0;
        end

        // Drain slots and anything past the image bottom feed zero.
        column[0] = upper_line[c];
        column[1] = lower_line[c];
        column[2] = (cmd == cv3_pkg::CMD_PIXEL && r < h) ? px : '0;
        upper_line[c] = column[1];
        lower_line[c] = column[2];
        for (int a = 0; a < 3; a++)
        begin
            window[a * 3]     = window[a * 3 + 1];
            window[a * 3 + 1] = window[a * 3 + 2];
            window[a * 3 + 2] = column[a];
        end

        has_result = (r >= 2) || (r == 1 && c >= 1);
        if (c >= 1)
        begin
            pc = c - 1;
            pr = r - 1;
        end
        else
        begin
            pc = w - 1;
            pr = r - 2;
        end

        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
        end
        if (!has_result)
        begin
            col_pos = c;
            row_pos = r;
            return;
        end

        is_last = (pr == h - 1 && pc == w - 1);
        if (is_last)
        begin
            c = 0;
            r = 0;
        end
        col_pos = c;
        row_pos = r;

        // Flipped kernel; taps that fall outside the image are masked to zero.
        for (int a = 0; a < 3; a++)
        begin
            for (int b = 0; b < 3; b++)
            begin
                if ((a == 0 && pr == 0) || (a == 2 && pr >= h - 1) ||
                    (b == 0 && pc == 0) || (b == 2 && pc >= w - 1))
                begin
                    continue;
                end
                coef = kernel_rows[2 - a][16 * (2 - b) +: 16];
                sum += longint'(coef) * longint'(window[a * 3 + b]);
            end
        end

        entry.value = sum[cv3_pkg::RESULT_W-1:0];
        entry.last  = is_last;
        expected_sums.push_back(entry);
    endfunction

    // Queue one frame of beats; a cut or noisy frame may stop early, a noisy one has random commands.
    function automatic int queue_frame(int unsigned w, int unsigned h, frame_style_t style);
        int unsigned len;
        int unsigned n;
        pixel_beat_t beat;

        len = w * h + w + 1;
        n   = (style == FRAME_CLEAN) ? len : $urandom_range(len, 1);
        for (int unsigned i = 0; i < n; i++)
        begin
            if (style == FRAME_NOISE)
            begin
                beat.command = 1'($urandom_range(1));
            end
            else
            begin
                beat.command = (i < w * h) ? cv3_pkg::CMD_PIXEL : CMD_DRAIN;
            end
            beat.sample = pick_sample();
            beats_pending.push_back(beat);
        end
        return n;
    endfunction

    task automatic report(string msg);
        error_count++;
        $display("%0t ns: %s", $time, msg);
    endtask

    // Register writes land at the next edge; the predictor follows at once since the
    // block is idle whenever a write is made.
    task automatic write_register(cv3_pkg::cfg_index_t which,
                                  logic [cv3_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_write_enable <= 1'b1;
        cfg_index        <= which;
        cfg_write_data   <= data;
        case (which)
            cv3_pkg::CFG_KERNEL_TOP:    kernel_rows[0] = data;
            cv3_pkg::CFG_KERNEL_MIDDLE: kernel_rows[1] = data;
            cv3_pkg::CFG_KERNEL_BOTTOM: kernel_rows[2] = data;
            cv3_pkg::CFG_IMAGE_WIDTH:
            begin
                width_setting = data[cv3_pkg::DIM_W-1:0];
                col_pos = 0;
                row_pos = 0;
            end
            cv3_pkg::CFG_IMAGE_HEIGHT:
            begin
                height_setting = data[cv3_pkg::DIM_W-1:0];
                col_pos = 0;
                row_pos = 0;
            end
            default: ;
        endcase
    endtask

    task automatic close_writes();
        @(posedge clk);
        cfg_write_enable <= 1'b0;
    endtask

    // Wait for every queued beat and every expected sum, then let the pipeline settle.
    task automatic wait_idle();
        while (beats_pending.size() != 0 || pixel_valid || expected_sums.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (IDLE_PAUSE) @(posedge clk);
    endtask

    // Pixel driver: predicts each accepted beat and offers the next one.
    always @(posedge clk)
    begin : drive_pixels
        logic        taken;
        pixel_beat_t beat;

        if (rst_n)
        begin
            taken = pixel_valid && pixel_ready;
            if (taken)
            begin
                predict_beat(command, pixel);
            end
            if ((!pixel_valid || taken) && beats_pending.size() != 0 &&
                $urandom_range(99) >= sender_idle_pct)
            begin
                beat = beats_pending.pop_front();
                pixel_valid <= 1'b1;
                command     <= beat.command;
                pixel       <= beat.sample;
            end
            else if (taken)
            begin
                pixel_valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each accepted beat against the oldest expected sum.
    always @(posedge clk)
    begin : check_results
        cv3_pkg::result_t want;

        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (expected_sums.size() == 0)
                begin
                    report($sformatf("result_value expected none, actual %0d (frame_end %0b)",
                                     result_value, frame_end));
                end
                else
                begin
                    want = expected_sums.pop_front();
                    if (result_value !== want.value)
                    begin
                        report($sformatf("result_value expected %0d, actual %0d",
                                         want.value, result_value));
                    end
                    if (frame_end !== want.last)
                    begin
                        report($sformatf("frame_end expected %0b, actual %0b",
                                         want.last, frame_end));
                    end
                end
            end
            result_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Progress watchdog: counts cycles in which no beat and no write is taken.
    always @(posedge clk)
    begin
        if (!rst_n || (pixel_valid && pixel_ready) || (result_valid && result_ready) ||
            cfg_write_enable)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        int           random_beats;
        int           phase;
        int unsigned  w;
        int unsigned  h;
        int unsigned  pick;
        frame_style_t style;

        for (int i = 0; i < LINE_MAX; i++)
        begin
            upper_line[i] = '0;
            lower_line[i] = '0;
        end
        foreach (window[i])
        begin
            window[i] = '0;
        end
        foreach (kernel_rows[i])
        begin
            kernel_rows[i] = '0;
        end
        width_setting  = 11'd1024;
        height_setting = 11'd1024;
        col_pos        = 0;
        row_pos        = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        fork
            begin
                // Extreme sums: every coefficient and pixel at the negative limit.
                write_register(cv3_pkg::CFG_KERNEL_TOP, {3{16'h8000}});
                write_register(cv3_pkg::CFG_KERNEL_MIDDLE, {3{16'h8000}});
                write_register(cv3_pkg::CFG_KERNEL_BOTTOM, {3{16'h8000}});
                write_register(cv3_pkg::CFG_IMAGE_WIDTH, 48'd3);
                write_register(cv3_pkg::CFG_IMAGE_HEIGHT, 48'd3);
                close_writes();
                for (int i = 0; i < 9; i++)
                begin
                    beats_pending.push_back({cv3_pkg::CMD_PIXEL, 16'h8000});
                end
                // A pixel command among the drain beats counts as a drain slot.
                beats_pending.push_back({CMD_DRAIN, 16'h7FFF});
                beats_pending.push_back({cv3_pkg::CMD_PIXEL, 16'h7FFF});
                beats_pending.push_back({CMD_DRAIN, 16'h7FFF});
                beats_pending.push_back({CMD_DRAIN, 16'h0000});

                // Positive limit pixels with a drain slot in the image center.
                for (int i = 0; i < 9; i++)
                begin
                    beats_pending.push_back({(i == 4) ? CMD_DRAIN : cv3_pkg::CMD_PIXEL,
                                             16'h7FFF});
                end
                for (int i = 0; i < 4; i++)
                begin
                    beats_pending.push_back({CMD_DRAIN, 16'hFFFF});
                end
                wait_idle();

                // Widest frame, reached through an oversized width setting.
                sender_idle_pct = 73;
                write_register(cv3_pkg::CFG_KERNEL_TOP,
                               {pick_sample(), pick_sample(), pick_sample()});
                write_register(cv3_pkg::CFG_IMAGE_WIDTH, 48'd2047);
                write_register(cv3_pkg::CFG_IMAGE_HEIGHT, 48'd1);
                close_writes();
                void'(queue_frame(LINE_MAX, 1, FRAME_CLEAN));
                wait_idle();

                // Random phases of small frames, rotating through the idling modes.
                random_beats = 0;
                phase        = 0;
                while (random_beats < RANDOM_BEATS || phase < MIN_PHASES)
                begin
                    case (phase % 4)
                        0:
                        begin
                            sender_idle_pct    = 0;
                            receiver_stall_pct = 0;
                        end
                        1:
                        begin
                            sender_idle_pct    = 73;
                            receiver_stall_pct = 0;
                        end
                        2:
                        begin
                            sender_idle_pct    = 0;
                            receiver_stall_pct = 73;
                        end
                        default:
                        begin
                            sender_idle_pct    = 23;
                            receiver_stall_pct = 23;
                        end
                    endcase

                    for (int row = 0; row < 3; row++)
                    begin
                        if ($urandom_range(9) < 6)
                        begin
                            write_register(
                                cv3_pkg::cfg_index_t'(int'(cv3_pkg::CFG_KERNEL_TOP) + row),
                                {pick_sample(), pick_sample(), pick_sample()});
                        end
                    end
                    // Most phases restart the frame; the rest continue where the last stopped.
                    if ($urandom_range(4) != 0)
                    begin
                        write_register(cv3_pkg::CFG_IMAGE_WIDTH,
                                       ($urandom_range(9) == 0) ? 48'd0 : 48'($urandom_range(8, 1)));
                        write_register(cv3_pkg::CFG_IMAGE_HEIGHT,
                                       ($urandom_range(9) == 0) ? 48'd0 : 48'($urandom_range(6, 1)));
                    end
                    close_writes();

                    w = effective_dim(width_setting, LINE_MAX);
                    h = effective_dim(height_setting, ROWS_MAX);
                    repeat ($urandom_range(3, 1))
                    begin
                        pick  = $urandom_range(9);
                        style = (pick == 0) ? FRAME_NOISE : (pick == 1) ? FRAME_CUT : FRAME_CLEAN;
                        random_beats += queue_frame(w, h, style);
                    end
                    wait_idle();
                    phase++;
                end
            end
            wait (stall_cycles >= STALL_LIMIT);
        join_any

        if (stall_cycles < STALL_LIMIT && error_count == 0 && expected_sums.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
